@@ hdl/mbe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

	// configuration register map
	localparam int CFG_INDEX_WIDTH = 1;
	localparam int CFG_DATA_WIDTH  = 16;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_ITER = 1'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHAPE    = 1'd1;

	localparam logic [CFG_DATA_WIDTH-1:0] MAX_ITER_RESET = 16'd50;
	localparam logic [CFG_DATA_WIDTH-1:0] SHAPE_RESET    = 16'd8192;

	// shape factor is unsigned Q4.12
	localparam int SHAPE_WIDTH = 16;
	localparam int SHAPE_FRAC  = 12;

	// integer bits of a coordinate (Q4.F)
	localparam int COORD_INT_BITS = 4;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MRR  = 8'b0000_0010,
		ST_MII  = 8'b0000_0100,
		ST_MRI  = 8'b0000_1000,
		ST_MLO  = 8'b0001_0000,
		ST_MHI  = 8'b0010_0000,
		ST_ACC  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

@@ hdl/mandelbrot_escape_iteration_unit.sv @@
// Each update steps through MRR, MII, MRI, MLO, MHI and ACC; the limit is checked in
// MRR and escape in MRI, either one ending the item in DONE. One item at a time; each
// update runs zr*zr, zi*zi, zr*zi and both shape partial products through the single
// shared multiplier; a new item is taken in the cycle after the result is registered.
// Reset: arst_n clears the sequencer and output valid, and restores max_iterations to
// 50 and shape_factor to 2.0; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_iteration_unit #(
	parameter int COORD_WIDTH = 32,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [COORD_WIDTH-1:0]        c_real,
	input  logic signed [COORD_WIDTH-1:0]        c_imag,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [COUNT_WIDTH-1:0]               iteration_count,
	input  logic                                 cfg_write,
	input  logic [mbe_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [mbe_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
	import mbe_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int F   = W - COORD_INT_BITS;
	localparam int MW  = W + 1;              // multiplier operand width
	localparam int PW  = 2 * MW;             // multiplier product width
	localparam int LOW = W + SHAPE_WIDTH;    // shape times low half of cross product
	localparam int TW  = PW + W;             // recombined shape product
	localparam int LW  = (COUNT_WIDTH > CFG_DATA_WIDTH) ? COUNT_WIDTH : CFG_DATA_WIDTH;

	localparam logic [PW:0] ESC_BOUND = {{PW{1'b0}}, 1'b1} << (2 * F + 2);

	state_t state_q;

	logic [CFG_DATA_WIDTH-1:0] max_iter_q;
	logic [SHAPE_WIDTH-1:0]    shape_q;
	logic                      out_valid_q;
	logic [COUNT_WIDTH-1:0]    count_out_q;

	logic signed [W-1:0]       cr_q, ci_q, zr_q, zi_q, cross_hi_q;
	logic [COUNT_WIDTH-1:0]    count_q, limit_q;
	logic signed [PW-1:0]      re2_q, im2_q, prod_q;
	logic [LOW-1:0]            lo_q;

	logic                      accept;
	logic                      result_load;
	logic signed [MW-1:0]      mul_a, mul_b;
	logic signed [PW-1:0]      mul_p;
	logic [MW-1:0]             shape_ext;

	logic [PW:0]               sq_sum;
	logic                      escape;

	logic signed [PW:0]        re_diff, re_diff_sh;
	logic signed [PW+1:0]      re_sum;
	logic signed [W-1:0]       re_sat;

	logic signed [TW-1:0]      im_total, im_total_sh;
	logic signed [TW:0]        im_sum;
	logic signed [W-1:0]       im_sat;

	logic [LW-1:0]             iter_ext, cnt_max_ext;
	logic [COUNT_WIDTH-1:0]    limit_eff;

	assign accept      = in_valid && !in_stall;
	assign in_stall    = (state_q != ST_IDLE);
	assign result_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid       = out_valid_q;
	assign iteration_count = count_out_q;

	// limit clamped to what the counter can hold
	assign iter_ext    = LW'(max_iter_q);
	assign cnt_max_ext = LW'({COUNT_WIDTH{1'b1}});
	assign limit_eff   = (iter_ext < cnt_max_ext) ? iter_ext[COUNT_WIDTH-1:0]
	                                              : {COUNT_WIDTH{1'b1}};

	assign shape_ext = {{(MW-SHAPE_WIDTH){1'b0}}, shape_q};

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MRR: begin
				mul_a = {zr_q[W-1], zr_q};
				mul_b = {zr_q[W-1], zr_q};
			end
			ST_MII: begin
				mul_a = {zi_q[W-1], zi_q};
				mul_b = {zi_q[W-1], zi_q};
			end
			ST_MRI: begin
				mul_a = {zr_q[W-1], zr_q};
				mul_b = {zi_q[W-1], zi_q};
			end
			ST_MLO: begin
				// low half of the cross product, taken as unsigned
				mul_a = {1'b0, prod_q[W-1:0]};
				mul_b = shape_ext;
			end
			ST_MHI: begin
				mul_a = {cross_hi_q[W-1], cross_hi_q};
				mul_b = shape_ext;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// escape when zr^2 + zi^2 is strictly above 4
	assign sq_sum = {re2_q[PW-1], re2_q} + {prod_q[PW-1], prod_q};
	assign escape = (sq_sum > ESC_BOUND);

	// new real part: floor((zr^2 - zi^2) >> F) + cr, saturated
	always_comb begin
		re_diff    = {re2_q[PW-1], re2_q} - {im2_q[PW-1], im2_q};
		re_diff_sh = re_diff >>> F;
		re_sum     = {re_diff_sh[PW], re_diff_sh} + {{(PW+2-W){cr_q[W-1]}}, cr_q};
		if ((&re_sum[PW+1:W-1]) || !(|re_sum[PW+1:W-1])) begin
			re_sat = re_sum[W-1:0];
		end else if (re_sum[PW+1]) begin
			re_sat = {1'b1, {(W-1){1'b0}}};
		end else begin
			re_sat = {1'b0, {(W-1){1'b1}}};
		end
	end

	// new imaginary part: recombine the two shape partial products
	always_comb begin
		im_total    = {prod_q, {W{1'b0}}} + {{(TW-LOW){1'b0}}, lo_q};
		im_total_sh = im_total >>> (F + SHAPE_FRAC);
		im_sum      = {im_total_sh[TW-1], im_total_sh} + {{(TW+1-W){ci_q[W-1]}}, ci_q};
		if ((&im_sum[TW:W-1]) || !(|im_sum[TW:W-1])) begin
			im_sat = im_sum[W-1:0];
		end else if (im_sum[TW]) begin
			im_sat = {1'b1, {(W-1){1'b0}}};
		end else begin
			im_sat = {1'b0, {(W-1){1'b1}}};
		end
	end

	// sequencer, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			max_iter_q  <= MAX_ITER_RESET;
			shape_q     <= SHAPE_RESET;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_MAX_ITER: max_iter_q <= cfg_data;
					REG_SHAPE:    shape_q    <= cfg_data;
					default:      ;
				endcase
			end

			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_MRR;
				end
				ST_MRR:  state_q <= (count_q >= limit_q) ? ST_DONE : ST_MII;
				ST_MII:  state_q <= ST_MRI;
				ST_MRI:  state_q <= escape ? ST_DONE : ST_MLO;
				ST_MLO:  state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_ACC;
				ST_ACC:  state_q <= ST_MRR;
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (accept) begin
			cr_q    <= c_real;
			ci_q    <= c_imag;
			zr_q    <= '0;
			zi_q    <= '0;
			count_q <= '0;
			limit_q <= limit_eff;
		end
		case (state_q)
			ST_MII: re2_q <= prod_q;
			ST_MRI: im2_q <= prod_q;
			ST_MLO: begin
				cross_hi_q <= prod_q[2*W-1:W];
				zr_q       <= re_sat;
			end
			ST_MHI: lo_q <= prod_q[LOW-1:0];
			ST_ACC: begin
				zi_q    <= im_sat;
				count_q <= count_q + 1'b1;
			end
			default: ;
		endcase
		if (result_load) begin
			count_out_q <= count_q;
		end
	end

endmodule

`default_nettype wire

@@ test/escape_count_monitor.sv @@
`timescale 1ns / 1ps

module escape_count_monitor #(
	parameter int COORD_WIDTH = 32,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [COORD_WIDTH-1:0]       c_real,
	input  logic signed [COORD_WIDTH-1:0]       c_imag,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [COUNT_WIDTH-1:0]              iteration_count,
	input  logic                                cfg_write,
	input  logic [mbe_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [mbe_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	output int                                  failures,
	output int                                  pending
);

	localparam int FRAC = COORD_WIDTH - mbe_pkg::COORD_INT_BITS;
	localparam int WIDE = 2 * COORD_WIDTH + mbe_pkg::SHAPE_WIDTH + 8;

	typedef logic signed [WIDE-1:0] wide_t;
	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct {
		logic [COUNT_WIDTH-1:0] count;
		coord_t                 cr;
		coord_t                 ci;
	} escape_rec_t;

	logic [mbe_pkg::CFG_DATA_WIDTH-1:0] iter_limit;
	logic [mbe_pkg::CFG_DATA_WIDTH-1:0] shape;
	escape_rec_t                        awaited_counts[$];
	escape_rec_t                        rec;
	escape_rec_t                        head;

	// saturate a full-width value to the signed coordinate range
	function automatic coord_t clamp_coord(wide_t v);
		wide_t upper;
		upper = v >>> (COORD_WIDTH - 1);
		if (upper == 0 || upper == -1)
			return v[COORD_WIDTH-1:0];
		if (v < 0)
			return {1'b1, {(COORD_WIDTH-1){1'b0}}};
		return {1'b0, {(COORD_WIDTH-1){1'b1}}};
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] predict_escape_count(
		coord_t cr, coord_t ci,
		logic [mbe_pkg::CFG_DATA_WIDTH-1:0] lim_reg,
		logic [mbe_pkg::CFG_DATA_WIDTH-1:0] shape_reg
	);
		longint unsigned cap;
		longint unsigned lim;
		longint unsigned n;
		wide_t zr, zi, rr, ii, nr, ni, cre, cim, scale, bound;
		cap = (64'd1 << COUNT_WIDTH) - 1;
		lim = (lim_reg < cap) ? lim_reg : cap;
		cre = cr;
		cim = ci;
		scale = shape_reg;
		bound = 1;
		bound = bound <<< (2 * FRAC + 2);
		zr = 0;
		zi = 0;
		n = 0;
		while (n < lim) begin
			rr = zr * zr;
			ii = zi * zi;
			// escape only when strictly beyond radius two
			if (rr + ii > bound)
				break;
			nr = ((rr - ii) >>> FRAC) + cre;
			ni = ((scale * (zr * zi)) >>> (FRAC + mbe_pkg::SHAPE_FRAC)) + cim;
			zr = clamp_coord(nr);
			zi = clamp_coord(ni);
			n++;
		end
		return n[COUNT_WIDTH-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_limit = mbe_pkg::MAX_ITER_RESET;
			shape = mbe_pkg::SHAPE_RESET;
			awaited_counts.delete();
			failures = 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == mbe_pkg::REG_MAX_ITER)
					iter_limit = cfg_data;
				else if (cfg_index == mbe_pkg::REG_SHAPE)
					shape = cfg_data;
			end
			if (in_valid && !in_stall) begin
				rec.cr = c_real;
				rec.ci = c_imag;
				rec.count = predict_escape_count(c_real, c_imag, iter_limit, shape);
				awaited_counts.push_back(rec);
			end
			if (out_valid && !out_stall) begin
				if (awaited_counts.size() == 0) begin
					$display("%t: result beat %0d with no point outstanding",
						$time, iteration_count);
					failures++;
				end else begin
					head = awaited_counts.pop_front();
					if (iteration_count !== head.count) begin
						$display("%t: iteration_count for c=(%h,%h): expected %0d, actual %0d",
							$time, head.cr, head.ci, head.count, iteration_count);
						failures++;
					end
				end
			end
		end
		pending = awaited_counts.size();
	end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	import mbe_pkg::*;

	localparam int COORD_WIDTH    = 32;
	localparam int COUNT_WIDTH    = 16;
	localparam int ITEMS          = 1900;
	localparam int CALM_TAIL      = 250;
	localparam int HOLD_CYCLES    = 400;
	localparam int IDLE_PAUSE     = 4;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 30000;

	// Q4.28 constants
	localparam int ONE      = 32'h1000_0000;
	localparam int NEG_ONE  = 32'hF000_0000;
	localparam int TWO      = 32'h2000_0000;
	localparam int NEG_TWO  = 32'hE000_0000;
	localparam int TWO_HALF = 32'h2800_0000;
	localparam int HALF     = 32'h0800_0000;
	localparam int QUARTER  = 32'h0400_0000;
	localparam int CUSP_OUT = 32'h0428_F5C3;
	localparam int NEG_3Q   = 32'hF400_0000;
	localparam int TENTH    = 32'h0199_999A;
	localparam int P3       = 32'h04CC_CCCD;
	localparam int P9       = 32'h0E66_6666;
	localparam int P14      = 32'h1666_6666;
	localparam int NEG_P14  = 32'hE999_999A;
	localparam int C_MAX    = 32'h7FFF_FFFF;
	localparam int C_MIN    = 32'h8000_0000;

	typedef enum int {PH_NORMAL, PH_ZERO_LIMIT, PH_HIGH_LIMIT} phase_kind_t;

	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_stall;
	logic signed [COORD_WIDTH-1:0]    c_real;
	logic signed [COORD_WIDTH-1:0]    c_imag;
	logic                             out_valid;
	logic                             out_stall;
	logic [COUNT_WIDTH-1:0]           iteration_count;
	logic                             cfg_write;
	logic [CFG_INDEX_WIDTH-1:0]       cfg_index;
	logic [CFG_DATA_WIDTH-1:0]        cfg_data;
	int                               failures;
	int                               pending;

	bit                               idle_on;
	bit                               hold_request;
	int                               points_sent;
	int                               settings;
	int                               quiet_cycles;
	int                               pick;
	int                               cr;
	int                               ci;
	logic [CFG_DATA_WIDTH-1:0]        limit;
	logic [CFG_DATA_WIDTH-1:0]        shape;
	phase_kind_t                      kind;

	mandelbrot_escape_iteration_unit #(
		.COORD_WIDTH(COORD_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.c_real(c_real),
		.c_imag(c_imag),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.iteration_count(iteration_count),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	escape_count_monitor #(
		.COORD_WIDTH(COORD_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.c_real(c_real),
		.c_imag(c_imag),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.iteration_count(iteration_count),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.failures(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// output side: random stall bursts, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// entered and left at a falling edge; valid stays high for the next point
	task automatic send_point(input int re, input int im);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid <= 1'b1;
		c_real <= re;
		c_imag <= im;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		points_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (IDLE_PAUSE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
		input logic [CFG_DATA_WIDTH-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		c_real = '0;
		c_imag = '0;
		cfg_write = 1'b0;
		cfg_index = REG_MAX_ITER;
		cfg_data = '0;
		idle_on = 1'b1;
		hold_request = 1'b0;
		points_sent = 0;
		settings = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: limit 50, ordinary set
		send_point(0, 0);
		send_point(C_MAX, 0);
		send_point(C_MIN, C_MIN);
		send_point(C_MIN, C_MAX);
		send_point(NEG_TWO, 0);
		send_point(TWO, 0);
		send_point(0, TWO);
		send_point(QUARTER, 0);
		send_point(CUSP_OUT, 0);
		send_point(NEG_ONE, 0);
		send_point(NEG_3Q, TENTH);
		wait_idle();

		// zero limit: no update at all
		write_reg(REG_MAX_ITER, 16'd0);
		send_point(0, 0);
		send_point(C_MAX, C_MIN);
		wait_idle();

		// no cross term, long run for a point that stays bounded
		write_reg(REG_MAX_ITER, 16'd1000);
		write_reg(REG_SHAPE, 16'd0);
		send_point(0, 0);
		send_point(HALF, TENTH);
		send_point(P3, P9);
		wait_idle();

		// widest limit and shape: saturating imaginary part, fast escapes only
		write_reg(REG_MAX_ITER, 16'hFFFF);
		write_reg(REG_SHAPE, 16'hFFFF);
		send_point(P14, P14);
		send_point(P14, NEG_P14);
		send_point(TWO_HALF, 0);
		send_point(C_MIN, 0);
		send_point(C_MAX, C_MAX);
		wait_idle();
		settings = 4;

		while (points_sent < ITEMS) begin
			pick = $urandom_range(0, 9);
			kind = phase_kind_t'((pick < 7) ? PH_NORMAL :
				(pick == 7) ? PH_ZERO_LIMIT : PH_HIGH_LIMIT);
			case (kind)
				PH_NORMAL: begin
					limit = 16'($urandom_range(1, 48));
				end
				PH_ZERO_LIMIT: begin
					limit = 16'd0;
				end
				default: begin
					limit = $urandom_range(0, 1) ? 16'hFFFF :
						16'($urandom_range(1000, 65535));
				end
			endcase
			pick = $urandom_range(0, 7);
			shape = (pick < 3) ? SHAPE_RESET : (pick == 3) ? 16'd0 :
				(pick == 4) ? 16'hFFFF : 16'($urandom);
			write_reg(REG_MAX_ITER, limit);
			write_reg(REG_SHAPE, shape);
			idle_on = (points_sent < ITEMS - CALM_TAIL);
			// fill the block while the output is held off
			if (settings == 6)
				hold_request = 1'b1;
			repeat ($urandom_range(20, 80)) begin
				pick = $urandom_range(0, 15);
				if (kind == PH_HIGH_LIMIT || pick == 0) begin
					// beyond radius two on the real axis alone: escapes after the first update
					cr = $urandom_range(TWO_HALF, C_MAX);
					if ($urandom_range(0, 1))
						cr = -cr;
					ci = $urandom;
				end else if (pick == 1) begin
					cr = $urandom;
					ci = $urandom;
				end else begin
					cr = $urandom_range(0, 3 * ONE) - 9 * (ONE / 4);
					ci = $urandom_range(0, 3 * ONE) - (3 * ONE) / 2;
				end
				send_point(cr, ci);
			end
			wait_idle();
			settings++;
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Covered %0d points over %0d register settings, limits 0 to 65535,",
			points_sent, settings);
		$display("shape factors 0 to 65535, and one %0d-cycle output hold-off.", HOLD_CYCLES);
		if (failures == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
